// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and a byte-level function for the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]   cfg_idx;
    logic [63:0]  cfg_data;
  } cfg_beat_t;

  // payload carried from cell to cell
  typedef struct packed {
    logic         valid;
    logic [127:0] state;
    logic [127:0] rkey;
  } cell_bus_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== rtl/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell
// One cipher round plus one key-schedule step, registered at its output.
// ----------------------------------------------------------------------------
module aes_round_cell import aes_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [7:0]       rcon_i,
  input  logic             last_i,
  input  cell_bus_t        bus_i,
  output cell_bus_t        bus_o
);

  logic [127:0] sub_sr, mixed, nkey;
  logic [7:0]   a0, a1, a2, a3, all;
  logic [31:0]  tw;
  cell_bus_t    bus_d;
  logic         valid_q;
  logic [127:0] state_q, rkey_q;

  always_comb begin
    // state byte 4*c+r sits at bits 8*(4c+r)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_sr[8*(4*c+r) +: 8] = SBOX[bus_i.state[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    mixed = sub_sr;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; all = '0;
    if (!last_i) begin
      for (int c = 0; c < 4; c++) begin
        a0 = sub_sr[32*c +: 8];
        a1 = sub_sr[32*c+8 +: 8];
        a2 = sub_sr[32*c+16 +: 8];
        a3 = sub_sr[32*c+24 +: 8];
        all = a0 ^ a1 ^ a2 ^ a3;
        mixed[32*c +: 8]    = a0 ^ all ^ gf_dbl(a0 ^ a1);
        mixed[32*c+8 +: 8]  = a1 ^ all ^ gf_dbl(a1 ^ a2);
        mixed[32*c+16 +: 8] = a2 ^ all ^ gf_dbl(a2 ^ a3);
        mixed[32*c+24 +: 8] = a3 ^ all ^ gf_dbl(a3 ^ a0);
      end
    end
    // rot-word, sub-word, rcon on the last word
    tw = {SBOX[bus_i.rkey[103:96]], SBOX[bus_i.rkey[127:120]],
          SBOX[bus_i.rkey[119:112]], SBOX[bus_i.rkey[111:104]] ^ rcon_i};
    nkey[31:0]   = bus_i.rkey[31:0] ^ tw;
    nkey[63:32]  = bus_i.rkey[63:32] ^ nkey[31:0];
    nkey[95:64]  = bus_i.rkey[95:64] ^ nkey[63:32];
    nkey[127:96] = bus_i.rkey[127:96] ^ nkey[95:64];
    bus_d.valid = bus_i.valid;
    bus_d.rkey  = nkey;
    bus_d.state = mixed ^ nkey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= bus_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= bus_d.state;
      rkey_q  <= bus_d.rkey;
    end
  end

  assign bus_o.valid = valid_q;
  assign bus_o.state = state_q;
  assign bus_o.rkey  = rkey_q;

endmodule

// ===== rtl/aes128_block_encrypt_core.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt_core
// AES-128 encryption as a chain of ten round cells with on-the-fly key expansion.
// ----------------------------------------------------------------------------
// One block enters per cycle while the chain advances; each of the ten round
// cells registers its result, each cell carrying its own round key to the next.
// The chain advances whenever its last cell is empty or its result is taken,
// so the output holds while stalled. Key writes are taken in any cycle; a
// block uses the key that was set when it entered the chain.
module aes128_block_encrypt_core import aes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_beat_t cfg_data_i
);

  logic [63:0] key_low_q, key_high_q;
  cell_bus_t   chain [NumRounds+1];
  logic        adv;

  assign adv         = !chain[NumRounds].valid || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_data_i.cfg_idx)
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i.cfg_data;
        CFG_KEY_HIGH: key_high_q <= cfg_data_i.cfg_data;
        default: ;
      endcase
    end
  end

  // initial add-round-key feeds the first cell
  always_comb begin
    chain[0].valid = in_valid_i;
    chain[0].rkey  = {key_high_q, key_low_q};
    chain[0].state = {in_data_i.block_high, in_data_i.block_low} ^ {key_high_q, key_low_q};
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .rcon_i (RCON[g]),
      .last_i (g == NumRounds - 1),
      .bus_i  (chain[g]),
      .bus_o  (chain[g+1])
    );
  end

  assign out_valid_o            = chain[NumRounds].valid;
  assign out_data_o.cipher_low  = chain[NumRounds].state[63:0];
  assign out_data_o.cipher_high = chain[NumRounds].state[127:64];

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");
  a_ready_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("chain stalled while output taken");
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !chain[NumRounds-1].valid |=> !out_valid_o)
    else $error("result appeared from empty chain");

endmodule
